@@ hw/rtl/prsm_pkg.sv @@
// ----------------------------------------------------------------------------
// prsm_pkg
// Shared constants and types of the per-class rehearsal slot manager.
// ----------------------------------------------------------------------------
package prsm_pkg;

  localparam int NUM_CLASSES = 64;
  localparam int MAX_SLOTS   = 64;
  localparam int CLS_W       = $clog2(NUM_CLASSES);
  localparam int FILL_W      = 7;
  localparam int IDX_W       = 12;
  localparam int TOT_W       = 13;
  localparam int THR_W       = 11;
  localparam int DIV_STEPS   = IDX_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  // register indexes on the config port
  localparam logic [1:0] REG_SLOTS  = 2'd0;
  localparam logic [1:0] REG_THRESH = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  localparam logic [FILL_W-1:0] SLOTS_RST  = 7'd16;
  localparam logic [THR_W-1:0]  THRESH_RST = 11'd1024;

  // write request into the fill memory
  typedef struct packed {
    logic              en;
    logic [CLS_W-1:0]  addr;
    logic [FILL_W-1:0] data;
  } fill_wr_t;

endpackage

@@ hw/rtl/prsm_fill_mem.sv @@
// ----------------------------------------------------------------------------
// prsm_fill_mem
// Per-class fill count memory, registered read, valid bit per entry.
// ----------------------------------------------------------------------------
module prsm_fill_mem (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic [prsm_pkg::CLS_W-1:0]  rd_addr,
  output logic [prsm_pkg::FILL_W-1:0] rd_data,
  input  prsm_pkg::fill_wr_t      wr
);
  import prsm_pkg::*;

  logic [FILL_W-1:0]      mem [NUM_CLASSES];
  logic [NUM_CLASSES-1:0] valid_r;
  logic [FILL_W-1:0]      rd_data_r;

  // valid bits: reset makes every class read as empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (wr.en) begin
      valid_r[wr.addr] <= 1'b1;
    end
  end

  // storage and registered read
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_data_r <= valid_r[rd_addr] ? mem[rd_addr] : '0;
  end

  assign rd_data = rd_data_r;

endmodule

@@ hw/rtl/prsm_div.sv @@
// ----------------------------------------------------------------------------
// prsm_div
// Restoring divider, one quotient bit per cycle, 12-bit dividend.
// ----------------------------------------------------------------------------
module prsm_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [prsm_pkg::IDX_W-1:0]  dividend,
  input  logic [prsm_pkg::FILL_W-1:0] divisor,
  output logic                       done,
  output logic [prsm_pkg::IDX_W-1:0]  quotient,
  output logic [prsm_pkg::FILL_W-1:0] remainder
);
  import prsm_pkg::*;

  logic                 busy_r, done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [IDX_W-1:0]     quo_r, quo_nxt;
  logic [FILL_W-1:0]    rem_r, rem_nxt, dvs_r;
  logic [FILL_W:0]      trial;
  logic                 ge;

  // one shift-subtract step
  always_comb begin
    trial   = {rem_r, quo_r[IDX_W-1]};
    ge      = trial >= {1'b0, dvs_r};
    rem_nxt = ge ? FILL_W'(trial - {1'b0, dvs_r}) : trial[FILL_W-1:0];
    quo_nxt = {quo_r[IDX_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

@@ hw/rtl/per_class_rehearsal_slot_manager_unit.sv @@
// ----------------------------------------------------------------------------
// per_class_rehearsal_slot_manager_unit
// Slot address manager of a class-balanced rehearsal buffer.
// ----------------------------------------------------------------------------
// Insert: a fill read, then the result when a slot is free or the sample is
//   dropped; a full class that replaces a drawn slot also waits on the divider.
// Lookup: two divides, a scan of the fill memory at one class per
//   cycle (up to 64), then one more divide; an empty buffer skips them all.
// One item at a time; the output register lets the next item in early.
// Synchronous active-low reset; fill counts read as zero at once after reset.
module per_class_rehearsal_slot_manager_unit
  import prsm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_action,
  input  logic [5:0]  in_label,
  input  logic [9:0]  in_candidate_draw,
  input  logic [5:0]  in_slot_draw,
  input  logic [11:0] in_global_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_valid_res,
  output logic [11:0] out_slot_address,
  output logic [5:0]  out_chosen_class,
  output logic [12:0] out_stored_total
);

  typedef enum logic [2:0] {
    S_IDLE, S_INS_RD, S_INS_DIV, S_LK_D1, S_LK_D2, S_SCAN, S_LK_D3, S_DONE
  } state_t;

  // config registers
  logic [FILL_W-1:0] slots_r;
  logic [THR_W-1:0]  thresh_r;
  logic              mode_r;
  logic              wr_beat;
  logic [FILL_W-1:0] n_eff;

  assign pready  = 1'b1;
  assign wr_beat = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_r  <= SLOTS_RST;
      thresh_r <= THRESH_RST;
      mode_r   <= 1'b1;
    end else if (wr_beat) begin
      unique case (paddr[3:2])
        REG_SLOTS:  slots_r  <= pwdata[FILL_W-1:0];
        REG_THRESH: thresh_r <= pwdata[THR_W-1:0];
        REG_MODE:   mode_r   <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SLOTS:  prdata = {25'd0, slots_r};
      REG_THRESH: prdata = {21'd0, thresh_r};
      REG_MODE:   prdata = {31'd0, mode_r};
      default:    prdata = '0;
    endcase
  end

  // clamp N into 1..MAX_SLOTS
  always_comb begin
    if (slots_r == '0)                      n_eff = FILL_W'(1);
    else if (slots_r > FILL_W'(MAX_SLOTS))  n_eff = FILL_W'(MAX_SLOTS);
    else                                    n_eff = slots_r;
  end

  // datapath state
  state_t            state_r;
  logic [CLS_W-1:0]  cls_r;
  logic [9:0]        cand_r;
  logic [5:0]        sdraw_r;
  logic [IDX_W-1:0]  gidx_r;
  logic [TOT_W-1:0]  total_r;
  logic [FILL_W-1:0] nonempty_r;
  logic [FILL_W-1:0] rsave_r;
  logic [CLS_W-1:0]  k_r, seen_r, scan_r;
  logic              res_valid_r;
  logic [IDX_W-1:0]  res_addr_r;
  logic [CLS_W-1:0]  res_cls_r;
  logic              out_valid_r, out_vres_r;
  logic [IDX_W-1:0]  out_addr_r;
  logic [CLS_W-1:0]  out_cls_r;
  logic [TOT_W-1:0]  out_tot_r;

  logic              in_beat;
  logic [CLS_W-1:0]  in_cls;
  logic [CLS_W-1:0]  rd_addr;
  logic [FILL_W-1:0] rd_data;
  fill_wr_t          fill_wr;
  logic              div_start, div_done;
  logic [IDX_W-1:0]  div_a, div_q;
  logic [FILL_W-1:0] div_b, div_r;
  logic [IDX_W-1:0]  base_addr;

  assign in_ready = (state_r == S_IDLE);
  assign in_beat  = in_valid && in_ready;
  assign in_cls   = mode_r ? in_label : '0;
  assign base_addr = IDX_W'(cls_r) * IDX_W'(n_eff);

  // memory read address follows the sequencer
  always_comb begin
    if (state_r == S_IDLE)      rd_addr = in_cls;
    else if (state_r == S_SCAN) rd_addr = scan_r + 1'b1;
    else                        rd_addr = '0;
  end

  // divider operands and start
  always_comb begin
    div_start = 1'b0;
    div_a     = gidx_r;
    div_b     = n_eff;
    fill_wr   = '0;
    unique case (state_r)
      S_IDLE: begin
        div_start = in_beat && in_action && (total_r != '0);
        div_a     = in_global_index;
      end
      S_INS_RD: begin
        div_a = {{(IDX_W-6){1'b0}}, sdraw_r};
        if (rd_data < n_eff) begin
          fill_wr.en   = 1'b1;
          fill_wr.addr = cls_r;
          fill_wr.data = rd_data + 1'b1;
        end else begin
          div_start = ({1'b0, cand_r} < thresh_r);
        end
      end
      S_LK_D1: begin
        div_start = div_done;
        div_a     = div_q;
        div_b     = nonempty_r;
      end
      S_SCAN: begin
        div_start = (rd_data != '0) && (seen_r == k_r);
        div_a     = {{(IDX_W-FILL_W){1'b0}}, rsave_r};
        div_b     = rd_data;
      end
      default: ;
    endcase
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      nonempty_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != S_DONE) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (in_beat) begin
            cls_r   <= in_cls;
            cand_r  <= in_candidate_draw;
            sdraw_r <= in_slot_draw;
            gidx_r  <= in_global_index;
            if (!in_action) begin
              state_r <= S_INS_RD;
            end else if (total_r == '0) begin
              res_valid_r <= 1'b0;
              res_addr_r  <= '0;
              res_cls_r   <= '0;
              state_r     <= S_DONE;
            end else begin
              state_r <= S_LK_D1;
            end
          end
        end
        S_INS_RD: begin
          res_cls_r <= cls_r;
          if (rd_data < n_eff) begin
            total_r <= total_r + 1'b1;
            if (rd_data == '0) nonempty_r <= nonempty_r + 1'b1;
            res_valid_r <= 1'b1;
            res_addr_r  <= base_addr + IDX_W'(rd_data);
            state_r     <= S_DONE;
          end else if ({1'b0, cand_r} < thresh_r) begin
            state_r <= S_INS_DIV;
          end else begin
            res_valid_r <= 1'b0;
            res_addr_r  <= '0;
            state_r     <= S_DONE;
          end
        end
        S_INS_DIV: begin
          if (div_done) begin
            res_valid_r <= 1'b1;
            res_addr_r  <= base_addr + IDX_W'(div_r);
            state_r     <= S_DONE;
          end
        end
        S_LK_D1: begin
          if (div_done) begin
            rsave_r <= div_r;
            state_r <= S_LK_D2;
          end
        end
        S_LK_D2: begin
          if (div_done) begin
            k_r     <= div_r[CLS_W-1:0];
            seen_r  <= '0;
            scan_r  <= '0;
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (rd_data != '0 && seen_r == k_r) begin
            cls_r   <= scan_r;
            state_r <= S_LK_D3;
          end else begin
            if (rd_data != '0) seen_r <= seen_r + 1'b1;
            scan_r <= scan_r + 1'b1;
            if (scan_r == CLS_W'(NUM_CLASSES - 1)) begin
              res_valid_r <= 1'b0;
              res_addr_r  <= '0;
              res_cls_r   <= '0;
              state_r     <= S_DONE;
            end
          end
        end
        S_LK_D3: begin
          if (div_done) begin
            res_valid_r <= 1'b1;
            res_addr_r  <= base_addr + IDX_W'(div_r);
            res_cls_r   <= cls_r;
            state_r     <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_vres_r  <= res_valid_r;
            out_addr_r  <= res_addr_r;
            out_cls_r   <= res_cls_r;
            out_tot_r   <= total_r;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  prsm_fill_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (fill_wr)
  );

  prsm_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign out_valid        = out_valid_r;
  assign out_valid_res    = out_vres_r;
  assign out_slot_address = out_addr_r;
  assign out_chosen_class = out_cls_r;
  assign out_stored_total = out_tot_r;

endmodule

@@ hw/rtl/prsm_checker.sv @@
// ----------------------------------------------------------------------------
// prsm_checker
// Port-level checks of the slot manager, bound to the top level.
// ----------------------------------------------------------------------------
module prsm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_valid_res,
  input logic [12:0] out_stored_total
);

  // a pending result beat is held until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat dropped while stalled");

  // a stored or found sample means the buffer is not empty
  a_res_total: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_valid_res |-> out_stored_total != 13'd0)
    else $error("valid result with empty buffer");

  // total never exceeds the buffer capacity
  a_total_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_stored_total <= 13'd4096)
    else $error("stored total above capacity");

  // no result right after reset
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result beat after reset");

endmodule

bind per_class_rehearsal_slot_manager_unit prsm_checker u_prsm_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_valid_res    (out_valid_res),
  .out_stored_total (out_stored_total)
);

@@ test/tb_per_class_rehearsal_slot_manager_unit.sv @@
// ----------------------------------------------------------------------------
// tb_per_class_rehearsal_slot_manager_unit
// Drives insert and lookup beats into the slot manager, predicts every result
// from its own copy of the class fill state, and checks each result beat in
// order. Runs several register settings, written over the config port while
// the block is idle.
// ----------------------------------------------------------------------------
module tb_per_class_rehearsal_slot_manager_unit;
  import prsm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic ACT_INSERT = 1'b0;
  localparam logic ACT_LOOKUP = 1'b1;
  localparam int   CYCLE_LIMIT = 900000;

  typedef struct packed {
    logic        action;
    logic [5:0]  label;
    logic [9:0]  cand;
    logic [5:0]  sdraw;
    logic [11:0] gidx;
  } req_t;

  typedef struct packed {
    logic        vres;
    logic [11:0] addr;
    logic [5:0]  cls;
    logic [12:0] total;
  } rsp_t;

  logic        clk, rst_n;
  logic        psel, penable, pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;
  logic        in_valid, in_ready;
  logic        in_action;
  logic [5:0]  in_label;
  logic [9:0]  in_candidate_draw;
  logic [5:0]  in_slot_draw;
  logic [11:0] in_global_index;
  logic        out_valid, out_ready;
  logic        out_valid_res;
  logic [11:0] out_slot_address;
  logic [5:0]  out_chosen_class;
  logic [12:0] out_stored_total;

  per_class_rehearsal_slot_manager_unit uut (.*);

  // clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [6:0]  slots_reg;
  logic [10:0] thresh_reg;
  logic        mode_reg;
  logic [6:0]  fill_cnt [NUM_CLASSES];
  logic [12:0] occupied;
  logic [6:0]  live_classes;

  req_t pending_beats [$];
  rsp_t expected_results [$];
  int   mismatches = 0;
  int   cycles = 0;
  bit   rx_quiet = 1'b0;      // idle-free stretch
  bit   tx_quiet = 1'b0;
  int   rx_hold = 0;          // long receiver hold-off, in cycles
  bit   hold_go = 1'b0;       // stimulus asks for the hold-off
  bit   hold_used = 1'b0;

  function automatic int unsigned eff_slots();
    if (slots_reg == 0) return 1;
    if (slots_reg > MAX_SLOTS) return MAX_SLOTS;
    return slots_reg;
  endfunction

  function automatic void add_beat(req_t r);
    pending_beats.insert(pending_beats.size(), r);
  endfunction

  // work out the slot result of one beat and update the fill state
  function automatic rsp_t predict_slot(req_t r);
    rsp_t        res;
    int unsigned n, c, k, seen, pick, slot;
    bit          hit;
    n = eff_slots();
    res = '0;
    if (r.action == ACT_INSERT) begin
      c = mode_reg ? r.label : 0;
      res.cls = 6'(c);
      if (fill_cnt[c] < n) begin
        slot = fill_cnt[c];
        if (fill_cnt[c] == 0) live_classes++;
        fill_cnt[c]++;
        occupied++;
        res.vres = 1'b1;
        res.addr = 12'(c * n + slot);
      end else if (r.cand < thresh_reg) begin
        res.vres = 1'b1;
        res.addr = 12'(c * n + (r.sdraw % n));
      end
    end else if (occupied != 0 && live_classes != 0) begin
      k = (r.gidx / n) % live_classes;
      seen = 0;
      hit = 1'b0;
      pick = 0;
      for (int i = 0; i < NUM_CLASSES; i++) begin
        if (!hit && fill_cnt[i] != 0) begin
          if (seen == k) begin
            pick = i;
            hit = 1'b1;
          end
          seen++;
        end
      end
      if (hit) begin
        slot = (r.gidx % n) % fill_cnt[pick];
        res.vres = 1'b1;
        res.addr = 12'(pick * n + slot);
        res.cls = 6'(pick);
      end
    end
    res.total = occupied;
    return res;
  endfunction

  // accepted input beat: predict at the edge
  logic in_taken;
  always @(posedge clk) begin
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && in_valid && in_ready) begin
      expected_results.insert(expected_results.size(),
                              predict_slot({in_action, in_label, in_candidate_draw,
                                            in_slot_draw, in_global_index}));
    end
  end

  // driver: offers queued beats, random gaps unless tx_quiet is set
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid          <= 1'b0;
      in_action         <= 1'b0;
      in_label          <= '0;
      in_candidate_draw <= '0;
      in_slot_draw      <= '0;
      in_global_index   <= '0;
    end else if (!in_valid || in_taken) begin
      if (pending_beats.size() != 0 && (tx_quiet || $urandom_range(99) >= 37)) begin
        in_valid          <= 1'b1;
        in_action         <= pending_beats[0].action;
        in_label          <= pending_beats[0].label;
        in_candidate_draw <= pending_beats[0].cand;
        in_slot_draw      <= pending_beats[0].sdraw;
        in_global_index   <= pending_beats[0].gidx;
        pending_beats.delete(0);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver stall pattern
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_go && !hold_used) begin
      hold_used <= 1'b1;
      rx_hold   <= 399;
      out_ready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold   <= rx_hold - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rx_quiet || ($urandom_range(99) >= 37);
    end
  end

  // monitor: compare each result beat with the oldest expectation
  always @(posedge clk) begin
    rsp_t got, want;
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready) begin
      got = {out_valid_res, out_slot_address, out_chosen_class, out_stored_total};
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", got);
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: valid_res %0d/%0d addr %0d/%0d class %0d/%0d total %0d/%0d",
                     want.vres, got.vres, want.addr, got.addr, want.cls, got.cls,
                     want.total, got.total);
        end
      end
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_SLOTS:  slots_reg  = val[6:0];
      REG_THRESH: thresh_reg = val[10:0];
      REG_MODE:   mode_reg   = val[0];
      default: ;
    endcase
  endtask

  // wait for the block to drain: every queued beat sent and every result seen
  task automatic drain();
    while (pending_beats.size() != 0 || in_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  function automatic req_t rand_beat(int unsigned lk_pct, int unsigned lbl_max);
    req_t r;
    r.action = ($urandom_range(99) < lk_pct) ? ACT_LOOKUP : ACT_INSERT;
    r.label  = 6'($urandom_range(lbl_max));
    r.cand   = 10'($urandom_range(1023));
    r.sdraw  = 6'($urandom_range(63));
    r.gidx   = 12'(($urandom_range(3) == 0) ? $urandom_range(4095) : $urandom_range(255));
    return r;
  endfunction

  function automatic req_t mk(logic a, logic [5:0] l, logic [9:0] c, logic [5:0] s,
                              logic [11:0] g);
    return {a, l, c, s, g};
  endfunction

  initial begin
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    slots_reg = SLOTS_RST; thresh_reg = THRESH_RST; mode_reg = 1'b1;
    occupied = 0; live_classes = 0;
    foreach (fill_cnt[i]) fill_cnt[i] = 0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // directed: empty lookup, extremes, tiny classes, full-class drop/replace
    reg_write(REG_SLOTS, 2);
    reg_write(REG_THRESH, 512);
    reg_write(REG_MODE, 1);
    add_beat(mk(ACT_LOOKUP, 0, 0, 0, 12'hFFF));
    add_beat(mk(ACT_INSERT, 63, 1023, 63, 0));
    add_beat(mk(ACT_INSERT, 63, 1023, 63, 0));
    add_beat(mk(ACT_INSERT, 63, 1023, 63, 0));
    add_beat(mk(ACT_INSERT, 63, 511, 63, 0));
    add_beat(mk(ACT_INSERT, 63, 512, 0, 0));
    add_beat(mk(ACT_INSERT, 0, 0, 0, 0));
    add_beat(mk(ACT_LOOKUP, 0, 0, 0, 0));
    add_beat(mk(ACT_LOOKUP, 0, 0, 0, 12'hFFF));
    add_beat(mk(ACT_LOOKUP, 0, 0, 0, 3));
    drain();
    // lowered N leaves fills above N; zero N acts as one
    reg_write(REG_SLOTS, 0);
    reg_write(REG_MODE, 0);
    add_beat(mk(ACT_INSERT, 42, 0, 63, 0));
    add_beat(mk(ACT_INSERT, 5, 1023, 0, 0));
    add_beat(mk(ACT_LOOKUP, 0, 0, 0, 12'hABC));
    drain();
    reg_write(REG_SLOTS, 127);
    reg_write(REG_THRESH, 1024);
    reg_write(REG_MODE, 1);
    add_beat(mk(ACT_INSERT, 7, 1023, 63, 0));
    add_beat(mk(ACT_LOOKUP, 0, 0, 0, 12'hFFF));
    add_beat(mk(ACT_LOOKUP, 0, 0, 0, 64));
    drain();

    // random phases over several settings
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin reg_write(REG_SLOTS, 1);  reg_write(REG_THRESH, 0);    end
        1: begin reg_write(REG_SLOTS, 4);  reg_write(REG_THRESH, 300);  end
        2: begin reg_write(REG_SLOTS, 64); reg_write(REG_THRESH, 1024); end
        3: begin reg_write(REG_SLOTS, 3);  reg_write(REG_THRESH, 700);
                 reg_write(REG_MODE, 0); end
        4: begin reg_write(REG_SLOTS, 9);  reg_write(REG_MODE, 1);      end
        default: begin reg_write(REG_SLOTS, 16); reg_write(REG_THRESH, 1); end
      endcase
      tx_quiet = (ph == 2);
      rx_quiet = (ph == 2);
      for (int i = 0; i < 180; i++)
        add_beat(rand_beat(ph == 2 ? 20 : 35, (ph == 1) ? 7 : 63));
      if (ph == 4) begin
        // long receiver hold-off while the sender keeps offering beats
        while (pending_beats.size() > 150) @(posedge clk);
        @(posedge clk);
        hold_go = 1'b1;
      end
      drain();
    end

    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ per_class_rehearsal_slot_manager_unit.f @@
hw/rtl/prsm_pkg.sv
hw/rtl/prsm_fill_mem.sv
hw/rtl/prsm_div.sv
hw/rtl/per_class_rehearsal_slot_manager_unit.sv
hw/rtl/prsm_checker.sv
test/tb_per_class_rehearsal_slot_manager_unit.sv
